### src/sxd_pkg.sv
// shared constants, codes, tables and structs for the sprite xor draw block
package sxd_pkg;

  // screen geometry and field widths
  localparam int SCREEN_W = 64;
  localparam int SCREEN_H = 32;
  localparam int ROW_W    = 64;
  localparam int SPR_W    = 8;
  localparam int MODE_W   = 2;
  localparam int POS_W    = 8;
  localparam int ROFF_W   = 4;
  localparam int CNT_W    = $clog2(ROW_W);
  localparam int COL_W    = CNT_W + 1;
  localparam int YA_W     = $clog2(SCREEN_H);
  localparam int YS_W     = POS_W;
  localparam int POS_N    = 2 ** POS_W;

  // item modes
  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_DRAW  = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  // wrap tables for the origin coordinates, built at elaboration
  typedef logic [CNT_W-1:0] xmod_tbl_t [POS_N];
  typedef logic [YA_W-1:0]  ymod_tbl_t [POS_N];

  function automatic xmod_tbl_t build_xmod();
    xmod_tbl_t t;
    for (int i = 0; i < POS_N; i++) begin
      t[i] = CNT_W'(i % SCREEN_W);
    end
    return t;
  endfunction

  function automatic ymod_tbl_t build_ymod();
    ymod_tbl_t t;
    for (int i = 0; i < POS_N; i++) begin
      t[i] = YA_W'(i % SCREEN_H);
    end
    return t;
  endfunction

  localparam xmod_tbl_t XMOD_TBL = build_xmod();
  localparam ymod_tbl_t YMOD_TBL = build_ymod();

  // row memory request
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic             clr;
    logic [YA_W-1:0]  addr;
    logic [ROW_W-1:0] wr_data;
  } mem_req_t;

  // serial xor unit request and response
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] x0;
    logic [SPR_W-1:0] sprite;
    logic [ROW_W-1:0] row;
  } ser_req_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [ROW_W-1:0] row;
  } ser_rsp_t;

endpackage

### src/sxd_ifs.sv
// valid/ready channel interfaces for sprite items and row results
interface sxd_in_if;
  logic                       valid;
  logic                       ready;
  logic [sxd_pkg::MODE_W-1:0] mode;
  logic [sxd_pkg::POS_W-1:0]  origin_x;
  logic [sxd_pkg::POS_W-1:0]  origin_y;
  logic [sxd_pkg::ROFF_W-1:0] row_offset;
  logic [sxd_pkg::SPR_W-1:0]  sprite_byte;
  logic                       first_row;

  modport source (
    output valid, mode, origin_x, origin_y, row_offset, sprite_byte, first_row,
    input  ready
  );
  modport sink (
    input  valid, mode, origin_x, origin_y, row_offset, sprite_byte, first_row,
    output ready
  );
endinterface

interface sxd_out_if;
  logic                      valid;
  logic                      ready;
  logic                      collision;
  logic [sxd_pkg::ROW_W-1:0] row_bits;

  modport source (output valid, collision, row_bits, input ready);
  modport sink (input valid, collision, row_bits, output ready);
endinterface

### src/sxd_rowmem.sv
// framebuffer row memory with per-row valid bits for reset and clear
module sxd_rowmem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sxd_pkg::mem_req_t         req,
  output logic [sxd_pkg::ROW_W-1:0] rd_data
);
  import sxd_pkg::*;

  logic [ROW_W-1:0]    mem [SCREEN_H];
  logic [SCREEN_H-1:0] valid_r;
  logic [ROW_W-1:0]    rd_data_r;
  logic                rd_hit_r;

  // storage write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  // row valid bits, a row not written since clear reads as blank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (req.clr) begin
        valid_r <= '0;
      end else if (req.wr_en) begin
        valid_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_hit_r <= valid_r[req.addr];
      end
    end
  end

  assign rd_data = rd_hit_r ? rd_data_r : '0;

endmodule

### src/sxd_xorser.sv
// bit-serial xor of a sprite row into a framebuffer row with hit detect
module sxd_xorser (
  input  logic              clk,
  input  logic              rst_n,
  input  sxd_pkg::ser_req_t req,
  output sxd_pkg::ser_rsp_t rsp
);
  import sxd_pkg::*;

  logic [ROW_W-1:0] row_sr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] x0_r;
  logic [SPR_W-1:0] spr_r;
  logic             busy_r;
  logic             hit_r;
  logic             done_r;

  logic [COL_W-1:0] col;
  logic [COL_W-1:0] x_lo;
  logic [COL_W-1:0] x_hi;
  logic             in_win;
  logic             pix_old;
  logic             pix_spr;
  logic             last;

  // column window of the sprite for the bit now at the head
  assign col     = {1'b0, cnt_r};
  assign x_lo    = {1'b0, x0_r};
  assign x_hi    = x_lo + COL_W'(SPR_W);
  assign in_win  = (col >= x_lo) && (col < x_hi) && (col < COL_W'(SCREEN_W));
  assign pix_old = row_sr_r[ROW_W-1];
  assign pix_spr = in_win && spr_r[SPR_W-1];
  assign last    = (cnt_r == CNT_W'(ROW_W - 1));

  // control: one column per cycle while busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      hit_r  <= 1'b0;
    end else begin
      done_r <= busy_r && last;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        hit_r  <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        hit_r <= hit_r | (pix_old & pix_spr);
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // data shift registers: row rotates once, sprite shifts inside the window
  always_ff @(posedge clk) begin
    if (req.start) begin
      row_sr_r <= req.row;
      spr_r    <= req.sprite;
      x0_r     <= req.x0;
    end else if (busy_r) begin
      row_sr_r <= {row_sr_r[ROW_W-2:0], pix_old ^ pix_spr};
      if (in_win) begin
        spr_r <= {spr_r[SPR_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.hit  = hit_r;
  assign rsp.row  = row_sr_r;

endmodule

### src/sprite_xor_draw_with_collision.sv
// top level: item sequencer around the row memory and the serial xor unit
//
// channel   dir  handshake            payload
// in_ch     in   in_ch.valid/ready    mode, origin_x, origin_y, row_offset,
//                                     sprite_byte, first_row
// out_ch    out  out_ch.valid/ready   collision, row_bits
//
// one item at a time; a draw reads the row, runs the bit-serial xor pass
// over the row and writes it back with the result. a read fetches the
// row; clear, off-screen draw and unused mode go straight to the result.
// reset blanks the screen at once through per-row valid bits and clears
// the collision flag. a stalled result holds until out_ch.ready, and no new
// item is taken until it leaves.
module sprite_xor_draw_with_collision (
  input  logic     clk,
  input  logic     rst_n,
  sxd_in_if.sink   in_ch,
  sxd_out_if.source out_ch
);
  import sxd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_XOR,
    S_RESULT
  } state_e;

  state_e           state_r;
  mode_e            mode_r;
  logic             flag_r;
  logic [YA_W-1:0]  addr_r;
  logic [CNT_W-1:0] x0_r;
  logic [SPR_W-1:0] spr_r;
  logic [ROW_W-1:0] row_out_r;

  logic             accept;
  logic [CNT_W-1:0] x_wrap;
  logic [YA_W-1:0]  y_wrap;
  logic [YS_W-1:0]  y_sum;
  logic             draw_ok;
  logic             is_draw;
  logic             is_read;
  logic [ROW_W-1:0] rd_data;
  mem_req_t         mem_req;
  ser_req_t         ser_req;
  ser_rsp_t         ser_rsp;

  // item decode and coordinate wrap
  assign accept  = in_ch.valid && in_ch.ready;
  assign x_wrap  = XMOD_TBL[in_ch.origin_x];
  assign y_wrap  = YMOD_TBL[in_ch.origin_y];
  assign y_sum   = YS_W'(y_wrap) + YS_W'(in_ch.row_offset);
  assign draw_ok = y_sum < YS_W'(SCREEN_H);
  assign is_draw = in_ch.mode == MODE_DRAW;
  assign is_read = in_ch.mode == MODE_READ;

  // row memory requests
  always_comb begin
    mem_req.rd_en   = accept && ((is_draw && draw_ok) || is_read);
    mem_req.clr     = accept && (in_ch.mode == MODE_CLEAR);
    mem_req.wr_en   = (state_r == S_XOR) && ser_rsp.done;
    mem_req.wr_data = ser_rsp.row;
    if (state_r == S_IDLE) begin
      mem_req.addr = is_read ? y_wrap : y_sum[YA_W-1:0];
    end else begin
      mem_req.addr = addr_r;
    end
  end

  // serial xor start once the row is out of memory
  assign ser_req.start  = (state_r == S_READ) && (mode_r == MODE_DRAW);
  assign ser_req.x0     = x0_r;
  assign ser_req.sprite = spr_r;
  assign ser_req.row    = rd_data;

  sxd_rowmem u_rowmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  sxd_xorser u_xorser (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ser_req),
    .rsp   (ser_rsp)
  );

  // sequencer, collision flag and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      flag_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            mode_r    <= mode_e'(in_ch.mode);
            x0_r      <= x_wrap;
            spr_r     <= in_ch.sprite_byte;
            addr_r    <= is_read ? y_wrap : y_sum[YA_W-1:0];
            row_out_r <= '0;
            unique case (in_ch.mode)
              MODE_DRAW: begin
                if (in_ch.first_row) begin
                  flag_r <= 1'b0;
                end
                state_r <= draw_ok ? S_READ : S_RESULT;
              end
              MODE_READ: begin
                state_r <= S_READ;
              end
              default: begin
                state_r <= S_RESULT;
              end
            endcase
          end
        end
        S_READ: begin
          if (mode_r == MODE_READ) begin
            row_out_r <= rd_data;
            state_r   <= S_RESULT;
          end else begin
            state_r <= S_XOR;
          end
        end
        S_XOR: begin
          if (ser_rsp.done) begin
            row_out_r <= ser_rsp.row;
            if (ser_rsp.hit) begin
              flag_r <= 1'b1;
            end
            state_r <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // channel outputs
  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = (state_r == S_RESULT);
  assign out_ch.collision = flag_r;
  assign out_ch.row_bits  = row_out_r;

endmodule

### bench/sxd_row_checker.sv
// checker for the sprite xor draw block: models the screen and compares every result
module sxd_row_checker (
  input  logic clk,
  input  logic rst_n,
  sxd_in_if    in_ch,
  sxd_out_if   out_ch,
  output int   mismatch_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import sxd_pkg::*;

  typedef struct packed {
    logic             collision;
    logic [ROW_W-1:0] row_bits;
  } row_result_t;

  // model screen, collision flag and results still owed by the block
  logic [ROW_W-1:0] screen_rows [SCREEN_H];
  logic             hit_flag;
  row_result_t      owed_rows [$];

  // xor one item onto the model screen and return what the block should answer
  function automatic row_result_t xor_draw_predict(
    logic [MODE_W-1:0] mode, logic [POS_W-1:0] ox, logic [POS_W-1:0] oy,
    logic [ROFF_W-1:0] roff, logic [SPR_W-1:0] sprite, logic first
  );
    row_result_t      res;
    int               x0;
    int               row;
    int               col;
    int               i;
    logic [ROW_W-1:0] cur;
    res.row_bits = '0;
    case (mode)
      MODE_CLEAR: begin
        for (i = 0; i < SCREEN_H; i++) screen_rows[i] = '0;
      end
      MODE_DRAW: begin
        x0  = int'(ox) % SCREEN_W;
        row = (int'(oy) % SCREEN_H) + int'(roff);
        if (first) hit_flag = 1'b0;
        // rows past the bottom are dropped, pixels past the right edge clipped
        if (row < SCREEN_H) begin
          cur = screen_rows[row];
          for (i = 0; i < SPR_W; i++) begin
            col = x0 + i;
            if (sprite[SPR_W-1-i] && col < SCREEN_W) begin
              if (cur[ROW_W-1-col]) hit_flag = 1'b1;
              cur[ROW_W-1-col] = ~cur[ROW_W-1-col];
            end
          end
          screen_rows[row] = cur;
          res.row_bits     = cur;
        end
      end
      MODE_READ: begin
        res.row_bits = screen_rows[int'(oy) % SCREEN_H];
      end
      default: begin
      end
    endcase
    res.collision = hit_flag;
    return res;
  endfunction

  // compare each result first, then predict the newly accepted item
  always @(posedge clk) begin
    row_result_t want;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      for (int r = 0; r < SCREEN_H; r++) screen_rows[r] = '0;
      hit_flag = 1'b0;
      owed_rows.delete();
      mismatch_count <= 0;
      pending_count  <= 0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (owed_rows.size() == 0) begin
          $error("result with no item waiting: collision %0d row_bits %h",
                 out_ch.collision, out_ch.row_bits);
          errs++;
        end else begin
          want = owed_rows.pop_front();
          if (out_ch.collision !== want.collision) begin
            $error("collision mismatch: expected %0d, actual %0d",
                   want.collision, out_ch.collision);
            errs++;
          end
          if (out_ch.row_bits !== want.row_bits) begin
            $error("row_bits mismatch: expected %h, actual %h",
                   want.row_bits, out_ch.row_bits);
            errs++;
          end
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        owed_rows.push_back(xor_draw_predict(in_ch.mode, in_ch.origin_x, in_ch.origin_y,
                                             in_ch.row_offset, in_ch.sprite_byte,
                                             in_ch.first_row));
      end
      mismatch_count <= mismatch_count + errs;
      pending_count  <= owed_rows.size();
    end
  end

endmodule

### bench/sprite_xor_draw_with_collision_tb.sv
// top of the sprite xor draw testbench: clock, reset, item traffic and verdict
module sprite_xor_draw_with_collision_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sxd_pkg::*;

  localparam int                ITEM_TARGET     = 1550;
  localparam int                DRAIN_CYCLES    = 80;
  localparam int                HOLD_OFF_AT     = 600;
  localparam int                HOLD_OFF_CYCLES = 400;
  localparam logic [MODE_W-1:0] MODE_UNUSED     = 2'd3;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   items_counted;
  int   send_calm;
  int   take_calm;
  int   results_taken;

  sxd_in_if  in_ch ();
  sxd_out_if out_ch ();

  sprite_xor_draw_with_collision DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sxd_row_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (fail_count),
    .pending_count  (pending_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #15_000_000;
    $display("FAILURE");
    $finish;
  end

  // wait length for one item, with occasional runs of back-to-back traffic
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // offer one item and hold it until the block takes it
  task automatic send_item(logic [MODE_W-1:0] mode, logic [POS_W-1:0] ox,
                           logic [POS_W-1:0] oy, logic [ROFF_W-1:0] roff,
                           logic [SPR_W-1:0] sprite, logic first);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.origin_x    <= ox;
    in_ch.origin_y    <= oy;
    in_ch.row_offset  <= roff;
    in_ch.sprite_byte <= sprite;
    in_ch.first_row   <= first;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_counted++;
  endtask

  // result side: random stalls, plus one long hold-off to back the block up
  initial begin
    int stall;
    results_taken = 0;
    take_calm     = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (results_taken == HOLD_OFF_AT) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        stall = draw_wait(take_calm);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && rst_n));
      results_taken++;
    end
  end

  // item traffic and verdict
  initial begin
    logic [POS_W-1:0]  pool_x [4];
    logic [POS_W-1:0]  pool_y [4];
    logic [POS_W-1:0]  seq_x;
    logic [POS_W-1:0]  seq_y;
    logic [SPR_W-1:0]  seq_rows [15];
    int                seq_len;
    int                pick;
    int                n;
    items_counted = 0;
    send_calm     = 0;
    seq_len       = 0;
    seq_x         = '0;
    seq_y         = '0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_CLEAR;
    in_ch.origin_x    <= '0;
    in_ch.origin_y    <= '0;
    in_ch.row_offset  <= '0;
    in_ch.sprite_byte <= '0;
    in_ch.first_row   <= 1'b0;
    rst_n             <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: blank read, overlap, wrap, clipping, bottom drop, unused mode, clear
    send_item(MODE_READ,   8'd0,   8'd0,   4'd0,  8'h00, 1'b0);
    send_item(MODE_DRAW,   8'd0,   8'd0,   4'd0,  8'hFF, 1'b1);
    send_item(MODE_DRAW,   8'd0,   8'd0,   4'd0,  8'h81, 1'b0);
    send_item(MODE_READ,   8'd0,   8'd32,  4'd0,  8'h00, 1'b0);
    send_item(MODE_DRAW,   8'd60,  8'd1,   4'd0,  8'hFF, 1'b1);
    send_item(MODE_DRAW,   8'd255, 8'd255, 4'd0,  8'hC0, 1'b0);
    send_item(MODE_DRAW,   8'd63,  8'd31,  4'd0,  8'hC0, 1'b0);
    send_item(MODE_DRAW,   8'd10,  8'd255, 4'd14, 8'hFF, 1'b1);
    send_item(MODE_DRAW,   8'd3,   8'd17,  4'd14, 8'h00, 1'b0);
    send_item(MODE_UNUSED, 8'd255, 8'd255, 4'd15, 8'hFF, 1'b1);
    send_item(MODE_DRAW,   8'd128, 8'd64,  4'd14, 8'hAA, 1'b1);
    send_item(MODE_DRAW,   8'd128, 8'd64,  4'd14, 8'h55, 1'b0);
    send_item(MODE_DRAW,   8'd128, 8'd64,  4'd14, 8'hFF, 1'b0);
    send_item(MODE_READ,   8'd0,   8'd14,  4'd0,  8'h00, 1'b0);
    send_item(MODE_CLEAR,  8'd255, 8'd255, 4'd14, 8'hFF, 1'b1);
    send_item(MODE_READ,   8'd0,   8'd31,  4'd0,  8'h00, 1'b0);
    send_item(MODE_READ,   8'd0,   8'd14,  4'd0,  8'h00, 1'b0);
    send_item(MODE_DRAW,   8'd56,  8'd0,   4'd0,  8'hFF, 1'b1);
    send_item(MODE_DRAW,   8'd57,  8'd0,   4'd0,  8'hFF, 1'b0);
    send_item(MODE_UNUSED, 8'd0,   8'd0,   4'd0,  8'h00, 1'b0);
    send_item(MODE_CLEAR,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0);

    // small origin pools so that sprites land on each other often
    for (int k = 0; k < 4; k++) begin
      pool_x[k] = POS_W'($urandom_range(0, 255));
      pool_y[k] = POS_W'($urandom_range(0, 255));
    end

    // random: mostly whole sprites, with reads, clears and loose items mixed in
    while (items_counted < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // sprite: redraw the last one to erase it, or a fresh one
        if (seq_len == 0 || $urandom_range(0, 3) != 0) begin
          seq_len = $urandom_range(1, 15);
          seq_x   = ($urandom_range(0, 9) < 7) ? pool_x[$urandom_range(0, 3)]
                                               : POS_W'($urandom_range(0, 255));
          seq_y   = ($urandom_range(0, 9) < 7) ? pool_y[$urandom_range(0, 3)]
                                               : POS_W'($urandom_range(0, 255));
          for (int k = 0; k < 15; k++) seq_rows[k] = SPR_W'($urandom_range(0, 255));
        end
        for (int k = 0; k < seq_len; k++) begin
          send_item(MODE_DRAW, seq_x, seq_y, ROFF_W'(k), seq_rows[k],
                    (k == 0) ? 1'b1 : ($urandom_range(0, 9) == 0));
        end
      end else if (pick < 85) begin
        // read back a few rows
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          send_item(MODE_READ, POS_W'($urandom_range(0, 255)),
                    ($urandom_range(0, 1) == 1) ? pool_y[$urandom_range(0, 3)] + POS_W'(k)
                                                : POS_W'($urandom_range(0, 255)),
                    ROFF_W'($urandom_range(0, 14)), SPR_W'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end
      end else if (pick < 88) begin
        send_item(MODE_CLEAR, POS_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 255)),
                  ROFF_W'($urandom_range(0, 14)), SPR_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else if (pick < 94) begin
        send_item(MODE_UNUSED, POS_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 255)),
                  ROFF_W'($urandom_range(0, 15)), SPR_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else begin
        send_item(MODE_DRAW, POS_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 255)),
                  ROFF_W'($urandom_range(0, 14)), SPR_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end
    end
    in_ch.valid <= 1'b0;

    // drain the owed results, then give the block time to show anything extra
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
